/* design/efr_pkg.sv */
// Shared types, codes and the CRC-16 step for the escaped frame receiver.
// No dependencies; the front, back and top files refer to it by scoped names.
package efr_pkg;

  // Line control codes
  localparam logic [7:0] CODE_START = 8'h8D;
  localparam logic [7:0] CODE_END   = 8'h8E;
  localparam logic [7:0] CODE_ESC   = 8'h8F;

  // CRC-16 polynomial (MSB first) and the reset value of crc_init
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_INIT_RESET = 16'h5635;

  // Bytes stored per frame must be at least this many on the end code
  localparam int unsigned MIN_FRAME = 4;

  // Depth of the command queue between front and back
  localparam int unsigned CMD_QUEUE_DEPTH = 4;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CRC      = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_ESCAPE   = 3'd4
  } status_t;

  // Command from front to back: either drain a good frame or report an error
  typedef struct packed {
    logic    drain;
    status_t status;
  } cmd_t;

  // One byte of CRC-16, polynomial 0x1021, MSB first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/efr_if.sv */
// Valid/ready channel interfaces: received line bytes and result items.
// Depends on nothing; payload widths are fixed by the block's fields.
interface efr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

/* design/efr_ram.sv */
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module efr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/efr_cmd_fifo.sv */
// Small register FIFO carrying commands from the front to the back.
// No package dependencies; width and depth come from parameters.
module efr_cmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* design/efr_front.sv */
// Front end: accepts line bytes, undoes escapes, keeps CRC and fill count,
// writes the frame store and queues drain or error commands. Uses efr_pkg.
module efr_front #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [15:0]                     cfg_wdata,
  efr_byte_if.sink                        in_ch,
  output logic                            ram_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            push,
  output efr_pkg::cmd_t                   push_cmd,
  output logic [$clog2(BUFFER_DEPTH)-1:0] push_idx,
  input  logic                            q_full,
  input  logic                            drain_done
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  logic          escape_pending, escape_pending_next;
  logic [CW-1:0] fill_count, fill_count_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [15:0]   crc_init;
  logic          busy, busy_next;

  logic          take;
  logic [7:0]    inv_byte;
  logic          store_req;
  logic [7:0]    store_val;
  logic          restart;

  // Hold off input while a good frame is being read out or the queue is full
  assign in_ch.ready = !busy && !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign inv_byte    = ~in_ch.rx_byte;

  // Classify the byte
  always_comb begin
    escape_pending_next = escape_pending;
    fill_count_next     = fill_count;
    running_crc_next    = running_crc;
    busy_next           = busy;
    store_req           = 1'b0;
    store_val           = in_ch.rx_byte;
    restart             = 1'b0;
    push                = 1'b0;
    push_cmd.drain      = 1'b0;
    push_cmd.status     = efr_pkg::ST_PAYLOAD;
    push_idx            = AW'(fill_count - CW'(3));
    ram_we              = 1'b0;
    ram_waddr           = fill_count[AW-1:0];
    ram_wdata           = store_val;

    if (take) begin
      if (escape_pending) begin
        if (inv_byte == efr_pkg::CODE_START || inv_byte == efr_pkg::CODE_END ||
            inv_byte == efr_pkg::CODE_ESC) begin
          escape_pending_next = 1'b0;
          store_req           = 1'b1;
          store_val           = inv_byte;
        end else begin
          push            = 1'b1;
          push_cmd.status = efr_pkg::ST_ESCAPE;
          restart         = 1'b1;
        end
      end else if (in_ch.rx_byte == efr_pkg::CODE_START) begin
        restart = 1'b1;
      end else if (in_ch.rx_byte == efr_pkg::CODE_ESC) begin
        escape_pending_next = 1'b1;
      end else if (in_ch.rx_byte == efr_pkg::CODE_END) begin
        push    = 1'b1;
        restart = 1'b1;
        if (fill_count < CW'(efr_pkg::MIN_FRAME)) begin
          push_cmd.status = efr_pkg::ST_SHORT;
        end else if (running_crc != 16'h0000) begin
          push_cmd.status = efr_pkg::ST_CRC;
        end else begin
          push_cmd.drain = 1'b1;
          busy_next      = 1'b1;
        end
      end else begin
        store_req = 1'b1;
      end
    end

    // Store one byte, or drop the frame when the store is full
    if (store_req) begin
      if (fill_count == CW'(BUFFER_DEPTH)) begin
        push            = 1'b1;
        push_cmd.status = efr_pkg::ST_OVERFLOW;
        restart         = 1'b1;
      end else begin
        ram_we           = 1'b1;
        ram_wdata        = store_val;
        fill_count_next  = fill_count + CW'(1);
        running_crc_next = efr_pkg::crc_add(running_crc, store_val);
      end
    end

    if (restart) begin
      fill_count_next     = '0;
      escape_pending_next = 1'b0;
      running_crc_next    = crc_init;
    end

    // Release the store once the back has issued its final read
    if (drain_done) begin
      busy_next = 1'b0;
    end

    // A configuration write also loads the CRC while nothing is gathered
    if (cfg_we && fill_count == '0) begin
      running_crc_next = cfg_wdata;
    end
  end

  // Front state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      fill_count     <= '0;
      running_crc    <= efr_pkg::CRC_INIT_RESET;
      crc_init       <= efr_pkg::CRC_INIT_RESET;
      busy           <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
      fill_count     <= fill_count_next;
      running_crc    <= running_crc_next;
      busy           <= busy_next;
      if (cfg_we) begin
        crc_init <= cfg_wdata;
      end
    end
  end

endmodule

/* design/efr_back.sv */
// Back end: pops commands, emits error items or reads a good frame out of the
// store one payload item per cycle unless stalled. Uses efr_pkg, efr_result_if.
module efr_back #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  efr_pkg::cmd_t                   q_cmd,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] q_idx,
  output logic                            pop,
  output logic                            ram_re,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]                      ram_rdata,
  efr_result_if.source                    out_ch,
  output logic                            drain_done
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic                draining, draining_next;
  logic [AW-1:0]       rd_idx, rd_idx_next;
  logic [AW-1:0]       last_idx, last_idx_next;
  logic                out_valid, out_valid_next;
  efr_pkg::status_t    out_status, out_status_next;
  logic                out_last, out_last_next;
  logic                from_ram, from_ram_next;
  logic                advance;

  // The RAM read register doubles as the output data register
  assign advance       = !out_valid || out_ch.ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.data   = from_ram ? ram_rdata : 8'h00;
  assign out_ch.last   = out_last;

  // Pick the next output item
  always_comb begin
    draining_next   = draining;
    rd_idx_next     = rd_idx;
    last_idx_next   = last_idx;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_last_next   = out_last;
    from_ram_next   = from_ram;
    pop             = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = rd_idx;
    drain_done      = 1'b0;

    if (advance) begin
      if (draining) begin
        ram_re          = 1'b1;
        out_valid_next  = 1'b1;
        out_status_next = efr_pkg::ST_PAYLOAD;
        from_ram_next   = 1'b1;
        out_last_next   = (rd_idx == last_idx);
        rd_idx_next     = rd_idx + AW'(1);
        if (rd_idx == last_idx) begin
          draining_next = 1'b0;
          drain_done    = 1'b1;
        end
      end else if (!q_empty) begin
        pop            = 1'b1;
        out_valid_next = 1'b1;
        if (q_cmd.drain) begin
          // Issue the first read now; a good frame has at least two payload items
          ram_re          = 1'b1;
          ram_raddr       = '0;
          out_status_next = efr_pkg::ST_PAYLOAD;
          from_ram_next   = 1'b1;
          out_last_next   = 1'b0;
          draining_next   = 1'b1;
          rd_idx_next     = AW'(1);
          last_idx_next   = q_idx;
        end else begin
          out_status_next = q_cmd.status;
          from_ram_next   = 1'b0;
          out_last_next   = 1'b1;
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      draining  <= draining_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and counters
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    last_idx   <= last_idx_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
    from_ram   <= from_ram_next;
  end

endmodule

/* design/escaped_frame_receiver_crc16_top.sv */
// Escaped frame receiver with CRC-16 check: top level.
// Error items and a good frame's first payload item go through the command queue
// and then the output registers. Throughput: one line byte per cycle unless the
// queue is full; input is held from the end code of a good frame until the last
// store read is issued; payload drains one per cycle while egress is ready.
// Reset: control state cleared, crc_init = 0x5635; store contents stay undefined.
module escaped_frame_receiver_crc16_top #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  efr_byte_if.sink      ingress,
  efr_result_if.source  egress
);

  localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
  localparam int unsigned QW   = $bits(efr_pkg::cmd_t) + AW;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          push;
  efr_pkg::cmd_t push_cmd;
  logic [AW-1:0] push_idx;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  logic [QW-1:0] q_rdata;
  efr_pkg::cmd_t q_cmd;
  logic [AW-1:0] q_idx;
  logic          drain_done;

  assign q_cmd = efr_pkg::cmd_t'(q_rdata[QW-1:AW]);
  assign q_idx = q_rdata[AW-1:0];

  efr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (ingress),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_idx   (push_idx),
    .q_full     (q_full),
    .drain_done (drain_done)
  );

  efr_cmd_fifo #(.WIDTH(QW), .DEPTH(efr_pkg::CMD_QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_cmd, push_idx}),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  efr_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  efr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (q_cmd),
    .q_idx      (q_idx),
    .pop        (pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_ch     (egress),
    .drain_done (drain_done)
  );

endmodule
